// ===== hw/rtl/pbsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbsa_pkg;

    localparam int unsigned BAR_SLOTS = 6;
    localparam int unsigned SLOT_W    = 3;
    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // Outcome codes
    localparam logic [2:0] OUT_IO_SKIP   = 3'd0;
    localparam logic [2:0] OUT_NO_WINDOW = 3'd1;
    localparam logic [2:0] OUT_WIDE_LAST = 3'd2;
    localparam logic [2:0] OUT_KEPT      = 3'd3;
    localparam logic [2:0] OUT_UNIMPL    = 3'd4;
    localparam logic [2:0] OUT_EXHAUSTED = 3'd5;
    localparam logic [2:0] OUT_ASSIGNED  = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_BASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SIZE   = 2'd3;

    localparam logic [1:0] BAR_TYPE_WIDE = 2'd2;

    typedef struct packed {
        logic              is_io;
        logic              wide;
        logic              wide_last;
        logic              placed;
        logic              mask_zero;
        logic [3:0]        flags;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] size;
    } item_t;

    typedef struct packed {
        logic [2:0]        outcome;
        logic              write_enable;
        logic [WORD_W-1:0] new_low_word;
        logic [WORD_W-1:0] new_high_word;
        logic              consumes_next_slot;
        logic [ADDR_W-1:0] region_size;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pbsa_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbsa_decode (
    input  wire logic [pbsa_pkg::SLOT_W-1:0] slot_index,
    input  wire logic [pbsa_pkg::WORD_W-1:0] orig_low_word,
    input  wire logic [pbsa_pkg::WORD_W-1:0] orig_high_word,
    input  wire logic [pbsa_pkg::WORD_W-1:0] probe_low_word,
    input  wire logic [pbsa_pkg::WORD_W-1:0] probe_high_word,
    output pbsa_pkg::item_t                  item
);
    import pbsa_pkg::*;

    logic              wide;
    logic [ADDR_W-1:0] placed_bits;
    logic [ADDR_W-1:0] raw_mask;
    logic [ADDR_W-1:0] mask;

    assign wide = (orig_low_word[2:1] == BAR_TYPE_WIDE);

    always_comb
    begin
        placed_bits = {(wide ? orig_high_word : {WORD_W{1'b0}}),
                       orig_low_word[WORD_W-1:4], 4'b0000};
        raw_mask    = {(wide ? probe_high_word : {WORD_W{1'b0}}),
                       probe_low_word[WORD_W-1:4], 4'b0000};
        // 32-bit BARs decode as if all bits above 31 were ones
        mask        = wide ? raw_mask : {{WORD_W{1'b1}}, raw_mask[WORD_W-1:0]};

        item.is_io     = orig_low_word[0];
        item.wide      = wide;
        item.wide_last = wide && ({1'b0, slot_index} >= 4'(BAR_SLOTS - 1));
        item.placed    = (placed_bits != '0);
        item.mask_zero = (raw_mask == '0);
        item.flags     = orig_low_word[3:0];
        item.mask      = mask;
        item.size      = ~mask + 64'd1;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pbsa_alloc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbsa_alloc (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [pbsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pbsa_pkg::ADDR_W-1:0]    cfg_data,
    input  wire pbsa_pkg::item_t                item,
    input  wire logic                           advance,
    output pbsa_pkg::result_t                   result
);
    import pbsa_pkg::*;

    logic [ADDR_W-1:0] narrow_base_reg, narrow_base_next;
    logic [ADDR_W-1:0] narrow_size_reg, narrow_size_next;
    logic [ADDR_W-1:0] wide_base_reg, wide_base_next;
    logic [ADDR_W-1:0] wide_size_reg, wide_size_next;
    logic [ADDR_W:0]   narrow_lim_reg, narrow_lim_next;
    logic [ADDR_W:0]   wide_lim_reg, wide_lim_next;
    logic [ADDR_W-1:0] narrow_free_reg, narrow_free_next;
    logic [ADDR_W-1:0] wide_free_reg, wide_free_next;

    logic [ADDR_W-1:0] sel_free;
    logic [ADDR_W-1:0] sel_wsize;
    logic [ADDR_W:0]   sel_lim;
    logic [ADDR_W:0]   bump;
    logic [ADDR_W-1:0] aligned;
    logic [ADDR_W:0]   region_end;
    logic              fits;
    logic              take;

    always_comb
    begin
        sel_free  = item.wide ? wide_free_reg : narrow_free_reg;
        sel_wsize = item.wide ? wide_size_reg : narrow_size_reg;
        sel_lim   = item.wide ? wide_lim_reg : narrow_lim_reg;
        // size - 1 equals ~mask whenever size is nonzero
        bump       = {1'b0, sel_free} + {1'b0, ~item.mask};
        aligned    = bump[ADDR_W-1:0] & item.mask;
        region_end = {1'b0, aligned} + {1'b0, item.size};
        fits = (sel_wsize != '0) && (item.size != '0) && !bump[ADDR_W]
            && (aligned != '0) && !region_end[ADDR_W]
            && (sel_lim[ADDR_W] || (region_end[ADDR_W-1:0] <= sel_lim[ADDR_W-1:0]));
    end

    always_comb
    begin
        result = '0;
        take   = 1'b0;
        if ((narrow_size_reg == '0) && (wide_size_reg == '0))
        begin
            result.outcome = OUT_NO_WINDOW;
        end
        else if (item.is_io)
        begin
            result.outcome = OUT_IO_SKIP;
        end
        else if (item.wide_last)
        begin
            result.outcome = OUT_WIDE_LAST;
        end
        else
        begin
            result.consumes_next_slot = item.wide;
            if (item.placed)
            begin
                result.outcome = OUT_KEPT;
            end
            else if (item.mask_zero)
            begin
                result.outcome      = OUT_UNIMPL;
                result.write_enable = 1'b1;
            end
            else
            begin
                result.write_enable = 1'b1;
                result.region_size  = item.size;
                if (fits)
                begin
                    take                 = 1'b1;
                    result.outcome       = OUT_ASSIGNED;
                    result.new_low_word  = aligned[WORD_W-1:0] | {28'd0, item.flags};
                    result.new_high_word = item.wide ? aligned[ADDR_W-1:WORD_W] : '0;
                end
                else
                begin
                    result.outcome = OUT_EXHAUSTED;
                end
            end
        end
    end

    always_comb
    begin
        narrow_base_next = narrow_base_reg;
        narrow_size_next = narrow_size_reg;
        wide_base_next   = wide_base_reg;
        wide_size_next   = wide_size_reg;
        narrow_lim_next  = narrow_lim_reg;
        wide_lim_next    = wide_lim_reg;
        narrow_free_next = narrow_free_reg;
        wide_free_next   = wide_free_reg;
        if (advance && take)
        begin
            if (item.wide)
                wide_free_next = region_end[ADDR_W-1:0];
            else
                narrow_free_next = region_end[ADDR_W-1:0];
        end
        if (cfg_write)
        begin
            case (cfg_index)
                REG_NARROW_BASE:
                begin
                    narrow_base_next = cfg_data;
                    narrow_free_next = cfg_data;
                    narrow_lim_next  = {1'b0, cfg_data} + {1'b0, narrow_size_reg};
                end
                REG_NARROW_SIZE:
                begin
                    narrow_size_next = cfg_data;
                    narrow_lim_next  = {1'b0, narrow_base_reg} + {1'b0, cfg_data};
                end
                REG_WIDE_BASE:
                begin
                    wide_base_next = cfg_data;
                    wide_free_next = cfg_data;
                    wide_lim_next  = {1'b0, cfg_data} + {1'b0, wide_size_reg};
                end
                REG_WIDE_SIZE:
                begin
                    wide_size_next = cfg_data;
                    wide_lim_next  = {1'b0, wide_base_reg} + {1'b0, cfg_data};
                end
                default:
                begin
                    narrow_base_next = narrow_base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_base_reg <= '0;
            narrow_size_reg <= '0;
            wide_base_reg   <= '0;
            wide_size_reg   <= '0;
            narrow_lim_reg  <= '0;
            wide_lim_reg    <= '0;
            narrow_free_reg <= '0;
            wide_free_reg   <= '0;
        end
        else
        begin
            narrow_base_reg <= narrow_base_next;
            narrow_size_reg <= narrow_size_next;
            wide_base_reg   <= wide_base_next;
            wide_size_reg   <= wide_size_next;
            narrow_lim_reg  <= narrow_lim_next;
            wide_lim_reg    <= wide_lim_next;
            narrow_free_reg <= narrow_free_next;
            wide_free_reg   <= wide_free_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pci_bar_size_and_allocate_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// BAR sizing and bump allocator.
// Input channel (in_valid/in_ready) carries one BAR word per transfer: slot
// index, the original low/high words and the all-ones probe read-back.
// Output channel (out_valid/out_ready) returns one result word per input word:
// outcome code, write enable, new BAR words, next-slot flag and region size.
// Configuration is a write-only port (cfg_write, cfg_index, cfg_data) holding
// the base and size of the 32-bit and 64-bit windows; writing a base also
// reloads that window's next-free pointer. Write it only while idle.
// An accepted word is loaded, decoded, into the input register; the allocation
// then moves to the result register once that register is free or drained.
// Throughput: one word per cycle while the receiver does not stall; the
// next-free pointer moves as each assigned word enters the result register.
// When the receiver stalls, the result register holds and the input register
// holds behind it; in_ready drops only when both are full.
// Reset clears the window registers, both pointers and all valid flags.

module pci_bar_size_and_allocate_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [pbsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pbsa_pkg::ADDR_W-1:0]    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [pbsa_pkg::SLOT_W-1:0]    slot_index,
    input  wire logic [pbsa_pkg::WORD_W-1:0]    orig_low_word,
    input  wire logic [pbsa_pkg::WORD_W-1:0]    orig_high_word,
    input  wire logic [pbsa_pkg::WORD_W-1:0]    probe_low_word,
    input  wire logic [pbsa_pkg::WORD_W-1:0]    probe_high_word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          outcome,
    output logic                                write_enable,
    output logic [pbsa_pkg::WORD_W-1:0]         new_low_word,
    output logic [pbsa_pkg::WORD_W-1:0]         new_high_word,
    output logic                                consumes_next_slot,
    output logic [pbsa_pkg::ADDR_W-1:0]         region_size
);
    import pbsa_pkg::*;

    item_t   dec_item;
    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t alloc_result;
    result_t result_reg;
    logic    result_valid_reg, result_valid_next;
    logic    advance;
    logic    in_fire;

    pbsa_decode u_decode (
        .slot_index      (slot_index),
        .orig_low_word   (orig_low_word),
        .orig_high_word  (orig_high_word),
        .probe_low_word  (probe_low_word),
        .probe_high_word (probe_high_word),
        .item            (dec_item)
    );

    pbsa_alloc u_alloc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_reg),
        .advance   (advance),
        .result    (alloc_result)
    );

    // Move the held word into the result register when that slot frees up
    assign advance  = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        item_valid_next   = in_fire || (item_valid_reg && !advance);
        result_valid_next = advance || (result_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= dec_item;
        if (advance)
            result_reg <= alloc_result;
    end

    assign out_valid          = result_valid_reg;
    assign outcome            = result_reg.outcome;
    assign write_enable       = result_reg.write_enable;
    assign new_low_word       = result_reg.new_low_word;
    assign new_high_word      = result_reg.new_high_word;
    assign consumes_next_slot = result_reg.consumes_next_slot;
    assign region_size        = result_reg.region_size;

    a_we_matches_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (write_enable == ((outcome == OUT_UNIMPL)
            || (outcome == OUT_EXHAUSTED) || (outcome == OUT_ASSIGNED))))
        else $error("write enable disagrees with outcome");

    a_words_zero_unless_assigned: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome != OUT_ASSIGNED)) |->
            ((new_low_word == '0) && (new_high_word == '0)))
        else $error("BAR words set without assignment");

    a_size_only_when_sized: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (region_size != '0)) |->
            ((outcome == OUT_EXHAUSTED) || (outcome == OUT_ASSIGNED)))
        else $error("region size reported for unsized outcome");

    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item_valid_reg && result_valid_reg && !out_ready))
        else $error("input stalled with free room");

endmodule

`default_nettype wire
